/* hw/rtl/fixed_radius_neighbor_pairs_macros.svh */
// Assertion macros shared by the neighbor pair search block.
`ifndef FIXED_RADIUS_NEIGHBOR_PAIRS_MACROS_SVH
`define FIXED_RADIUS_NEIGHBOR_PAIRS_MACROS_SVH

// Plain implication check, sampled on the rising clock edge outside reset.
`define FRNP_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Invariant check that holds on every clock edge outside reset.
`define FRNP_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`endif

/* hw/rtl/frnp_pkg.sv */
// Package with sizes, types and codes of the neighbor pair search block.
package frnp_pkg;

   localparam int CAPACITY      = 256;
   localparam int MAX_NEIGHBORS = 16;

   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int HC_W      = $clog2(MAX_NEIGHBORS + 1);
   localparam int HIT_IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

   localparam int ID_W    = 32;
   localparam int POS_W   = 24;
   localparam int STATE_W = 8;
   localparam int DIST_W  = 52;
   localparam int MAG_W   = POS_W + 1;
   localparam int SQ_W    = 2 * MAG_W;

   localparam logic [DIST_W-1:0] CUTOFF_RESET = DIST_W'(64'd16777216);

   // Action codes carried by the request beat.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]         id;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [STATE_W-1:0]      state;
   } particle_type;

   typedef struct packed {
      logic               hit;
      logic [ID_W-1:0]    id;
      logic [STATE_W-1:0] state;
   } hit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_EMIT
   } frnp_state_type;

endpackage

/* hw/rtl/frnp_if.sv */
// Channel interfaces: request, response and control register write.
interface frnp_req_if import frnp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    action;
   logic [ID_W-1:0]         particle_id;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic [STATE_W-1:0]      particle_state;

   modport source (output valid, action, particle_id, pos_x, pos_y, pos_z, particle_state,
                   input ready);
   modport sink   (input valid, action, particle_id, pos_x, pos_y, pos_z, particle_state,
                   output ready);
endinterface

interface frnp_rsp_if import frnp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    new_id;
   logic [ID_W-1:0]    other_id;
   logic [STATE_W-1:0] other_state;
   logic               found;
   logic               list_overflow;
   logic               store_full;
   logic               last_result;

   modport source (output valid, new_id, other_id, other_state, found, list_overflow,
                   store_full, last_result, input ready);
   modport sink   (input valid, new_id, other_id, other_state, found, list_overflow,
                   store_full, last_result, output ready);
endinterface

interface frnp_csr_if import frnp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/frnp_cell.sv */
// One storage cell of the rotating particle chain.
module frnp_cell import frnp_pkg::*; (
   input  logic         clock,
   input  logic         shift,
   input  logic         load,
   input  particle_type load_data,
   input  particle_type nbr_data,
   output particle_type data
);

   particle_type data_ff;

   // A load writes the new particle; a shift takes the neighbor's particle.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end else if (shift) begin
         data_ff <= nbr_data;
      end
   end

   assign data = data_ff;

endmodule

/* hw/rtl/frnp_dist.sv */
// Distance unit: squares the coordinate gaps, then sums and tests the cutoff.
module frnp_dist import frnp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid,
   input  particle_type      probe,
   input  particle_type      stored,
   input  logic [DIST_W-1:0] cutoff,
   output hit_type           result
);

   logic signed [MAG_W-1:0] dx, dy, dz;
   logic [MAG_W-1:0]        mx, my, mz;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff, sqz_ff;
   logic                    valid_ff;
   logic [ID_W-1:0]         id_ff;
   logic [STATE_W-1:0]      state_ff;
   logic [DIST_W-1:0]       sum;

   // Magnitudes of the coordinate gaps.
   always_comb begin
      dx = MAG_W'(probe.x) - MAG_W'(stored.x);
      dy = MAG_W'(probe.y) - MAG_W'(stored.y);
      dz = MAG_W'(probe.z) - MAG_W'(stored.z);
      mx = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      my = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      mz = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
   end

   // Square stage, registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff   <= mx * mx;
      sqy_ff   <= my * my;
      sqz_ff   <= mz * mz;
      id_ff    <= stored.id;
      state_ff <= stored.state;
   end

   // Sum of the squares fits in the compare width without overflow.
   always_comb begin
      sum          = DIST_W'(sqx_ff) + DIST_W'(sqy_ff) + DIST_W'(sqz_ff);
      result.hit   = valid_ff && (sum <= cutoff);
      result.id    = id_ff;
      result.state = state_ff;
   end

endmodule

/* hw/rtl/fixed_radius_neighbor_pairs.sv */
// Fixed-radius neighbor pair search over a rotating chain of stored particles.
// An insert scans the store, loads the particle unless full, then emits one result per
// hit (one if none); a clear empties the store and emits one. Requests wait until idle.
// The scan rate is set by the chain rotating one cell per cycle past one distance unit.
// Reset empties the store and sets the cutoff to 1.0; stored particles are not cleared.
`include "fixed_radius_neighbor_pairs_macros.svh"

module fixed_radius_neighbor_pairs import frnp_pkg::*; (
   input logic         clock,
   input logic         reset,
   frnp_req_if.sink    req_bus,
   frnp_rsp_if.source  rsp_bus,
   frnp_csr_if.sink    csr_bus
);

   frnp_state_type     state_ff, state_in;
   logic [DIST_W-1:0]  cutoff_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   scan_ff;
   particle_type       cur_ff;
   logic               clr_ff;
   logic               full_ff;
   logic [HC_W-1:0]    hit_cnt_ff;
   logic               ovf_ff;
   logic [HC_W-1:0]    emit_ff;
   logic [ID_W-1:0]    hit_id_ff [MAX_NEIGHBORS];
   logic [STATE_W-1:0] hit_st_ff [MAX_NEIGHBORS];

   logic               rsp_valid_ff;
   logic [ID_W-1:0]    rsp_new_id_ff, rsp_other_id_ff;
   logic [STATE_W-1:0] rsp_other_state_ff;
   logic               rsp_found_ff, rsp_ovf_ff, rsp_full_ff, rsp_last_ff;

   logic               req_fire, do_shift, dist_valid, do_load, emit_fire, is_last;
   particle_type       cell_data [CAPACITY];
   particle_type       new_particle;
   hit_type            dist_res;

   assign req_fire = req_bus.valid && req_bus.ready;

   always_comb begin
      new_particle.id    = req_bus.particle_id;
      new_particle.x     = req_bus.pos_x;
      new_particle.y     = req_bus.pos_y;
      new_particle.z     = req_bus.pos_z;
      new_particle.state = req_bus.particle_state;
   end

   // Chain of cells; cell zero feeds the distance unit and the row rotates.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      frnp_cell u_cell (
         .clock     (clock),
         .shift     (do_shift),
         .load      (do_load && (fill_ff == CNT_W'(i))),
         .load_data (cur_ff),
         .nbr_data  (cell_data[(i + 1) % CAPACITY]),
         .data      (cell_data[i])
      );
   end

   frnp_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .valid  (dist_valid),
      .probe  (cur_ff),
      .stored (cell_data[0]),
      .cutoff (cutoff_ff),
      .result (dist_res)
   );

   assign is_last = (hit_cnt_ff == '0) || (emit_ff == hit_cnt_ff - HC_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_bus.action == ACT_CLEAR) ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == CNT_W'(CAPACITY - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_fire && is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_bus.ready = 1'b0;
      do_shift      = 1'b0;
      dist_valid    = 1'b0;
      do_load       = 1'b0;
      emit_fire     = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_bus.ready = 1'b1;
         ST_SCAN: begin
            do_shift   = 1'b1;
            dist_valid = scan_ff < fill_ff;
         end
         ST_FLUSH: do_load = !full_ff;
         ST_EMIT:  emit_fire = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   assign csr_bus.ready = 1'b1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cutoff_ff  <= CUTOFF_RESET;
         fill_ff    <= '0;
         scan_ff    <= '0;
         hit_cnt_ff <= '0;
         ovf_ff     <= 1'b0;
         emit_ff    <= '0;
         clr_ff     <= 1'b0;
         full_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid) begin
            cutoff_ff <= csr_bus.data;
         end
         if (req_fire) begin
            scan_ff    <= '0;
            hit_cnt_ff <= '0;
            ovf_ff     <= 1'b0;
            emit_ff    <= '0;
            clr_ff     <= (req_bus.action == ACT_CLEAR);
            full_ff    <= (req_bus.action != ACT_CLEAR) && (fill_ff >= CNT_W'(CAPACITY));
            if (req_bus.action == ACT_CLEAR) begin
               fill_ff <= '0;
            end
         end
         if (do_shift) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
         if (dist_res.hit) begin
            if (hit_cnt_ff < HC_W'(MAX_NEIGHBORS)) begin
               hit_cnt_ff <= hit_cnt_ff + HC_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (do_load) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
         if (emit_fire) begin
            emit_ff <= emit_ff + HC_W'(1);
         end
      end
   end

   // Payload registers: current particle and the hit list.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_ff <= new_particle;
      end
      if (dist_res.hit && (hit_cnt_ff < HC_W'(MAX_NEIGHBORS))) begin
         hit_id_ff[hit_cnt_ff[HIT_IDX_W-1:0]] <= dist_res.id;
         hit_st_ff[hit_cnt_ff[HIT_IDX_W-1:0]] <= dist_res.state;
      end
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_new_id_ff <= clr_ff ? '0 : cur_ff.id;
         rsp_found_ff  <= (hit_cnt_ff != '0);
         rsp_ovf_ff    <= ovf_ff;
         rsp_full_ff   <= full_ff;
         rsp_last_ff   <= is_last;
         if (hit_cnt_ff != '0) begin
            rsp_other_id_ff    <= hit_id_ff[emit_ff[HIT_IDX_W-1:0]];
            rsp_other_state_ff <= hit_st_ff[emit_ff[HIT_IDX_W-1:0]];
         end else begin
            rsp_other_id_ff    <= '0;
            rsp_other_state_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.new_id        = rsp_new_id_ff;
   assign rsp_bus.other_id      = rsp_other_id_ff;
   assign rsp_bus.other_state   = rsp_other_state_ff;
   assign rsp_bus.found         = rsp_found_ff;
   assign rsp_bus.list_overflow = rsp_ovf_ff;
   assign rsp_bus.store_full    = rsp_full_ff;
   assign rsp_bus.last_result   = rsp_last_ff;

   // Checks on the sequencer and counters.
   `FRNP_ALWAYS(a_fill_bound, fill_ff <= CNT_W'(CAPACITY), "fill count beyond capacity")
   `FRNP_ALWAYS(a_hit_bound, hit_cnt_ff <= HC_W'(MAX_NEIGHBORS), "hit count beyond limit")
   `FRNP_CHECK(a_busy_after_req, req_fire |=> state_ff != ST_IDLE, "idle after accepted beat")
   `FRNP_CHECK(a_hit_in_scan, dist_res.hit |-> (state_ff == ST_SCAN || state_ff == ST_FLUSH), "hit outside scan")

endmodule
